FILE: rtl/assert_macros.svh
// Assertion macros shared by the nearest palette color RTL.
// Included by nearest_palette_color, which carries the concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NPC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("npc assertion failed");
`define NPC_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("npc forbidden condition");
`else
`define NPC_ASSERT(lbl, clk, rst_n, prop)
`define NPC_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: rtl/npc_pkg.sv
// Package for the nearest palette color search: constants, token type,
// color distance function. No dependencies.
`default_nettype none
package npc_pkg;
	localparam int NPC_DEPTH    = 64;
	localparam int COLOR_W      = 24;
	localparam int CHAN_W       = 8;
	localparam int DIST_W       = 18;
	localparam int IDX_OUT_W    = 6;
	localparam int CNT_W        = 7;
	localparam logic [CNT_W-1:0] CNT_RESET = 7'd60;
	localparam logic [CHAN_W-1:0] CHAN_MASK = 8'hFF;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic               valid;
		logic [COLOR_W-1:0] color;
		logic [DIST_W-1:0]  best_d;
	} tok_t;

	function automatic logic [DIST_W-1:0] color_dist(
		input logic [COLOR_W-1:0] a,
		input logic [COLOR_W-1:0] b
	);
		logic [CHAN_W-1:0]  ca;
		logic [CHAN_W-1:0]  cb;
		logic [CHAN_W-1:0]  d;
		logic [DIST_W-1:0]  acc;
		acc = '0;
		for (int c = 0; c < 3; c++) begin
			ca = a[c*CHAN_W +: CHAN_W] & CHAN_MASK;
			cb = b[c*CHAN_W +: CHAN_W] & CHAN_MASK;
			d = (ca >= cb) ? (ca - cb) : (cb - ca);
			acc = acc + DIST_W'({8'd0, d} * {8'd0, d});
		end
		return acc;
	endfunction
endpackage
`default_nettype wire

FILE: rtl/npc_if.sv
// Request channels of the nearest palette color search: input, result
// and configuration write. Depends on npc_pkg.
`default_nettype none
interface npc_in_if import npc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [5:0]         entry_index;
	logic [COLOR_W-1:0] color;
	modport source (output valid, opcode, entry_index, color, input ready);
	modport sink (input valid, opcode, entry_index, color, output ready);
endinterface

interface npc_out_if import npc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [IDX_OUT_W-1:0] nearest_index;
	logic [DIST_W-1:0]    nearest_distance;
	modport source (output valid, nearest_index, nearest_distance, input ready);
	modport sink (input valid, nearest_index, nearest_distance, output ready);
endinterface

interface npc_cfg_if import npc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] entries_in_use;
	modport source (output valid, entries_in_use, input ready);
	modport sink (input valid, entries_in_use, output ready);
endinterface
`default_nettype wire

FILE: rtl/npc_cell.sv
// One palette cell: holds one entry, scores the passing query token against
// it and hands the updated running minimum to the next cell. Uses npc_pkg.
`default_nettype none
module npc_cell import npc_pkg::*; #(
	parameter int IdxW  = 6,
	parameter int Index = 0
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic               wr_en,
	input  wire logic [COLOR_W-1:0] wr_color,
	input  wire logic               active,
	input  wire tok_t               tok_i,
	input  wire logic [IdxW-1:0]    best_i_i,
	output tok_t                    tok_o,
	output logic [IdxW-1:0]         best_i_o
);
	logic [COLOR_W-1:0] entry_q;
	logic               vld_q;
	logic [COLOR_W-1:0] color_q;
	logic [DIST_W-1:0]  best_d_q;
	logic [IdxW-1:0]    best_i_q;
	logic [DIST_W-1:0]  cur_d;
	logic               take;

	assign cur_d = color_dist(tok_i.color, entry_q);
	assign take  = active && (cur_d < tok_i.best_d);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= wr_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= tok_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			color_q  <= tok_i.color;
			best_d_q <= take ? cur_d : tok_i.best_d;
			best_i_q <= take ? IdxW'(Index) : best_i_i;
		end
	end

	assign tok_o.valid  = vld_q;
	assign tok_o.color  = color_q;
	assign tok_o.best_d = best_d_q;
	assign best_i_o     = best_i_q;
endmodule
`default_nettype wire

FILE: rtl/nearest_palette_color.sv
// Nearest palette color search: a row of PALETTE_DEPTH cells, one entry each.
// A query token moves one cell per cycle unless the row is held by an unaccepted
// result; its result is registered at the end of the row. One query is in flight
// at a time: no write or query is taken until that query's result is loaded.
// Reset clears control state and sets entries_in_use to 60; palette entries
// are undefined until written.
`default_nettype none
`include "assert_macros.svh"
module nearest_palette_color import npc_pkg::*; #(
	parameter int PALETTE_DEPTH = NPC_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	npc_in_if.sink   in,
	npc_out_if.source out,
	npc_cfg_if.sink  cfg
);
	localparam int IdxW = $clog2(PALETTE_DEPTH);

	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 out_vld_q;
	logic [IDX_OUT_W-1:0] out_idx_q;
	logic [DIST_W-1:0]    out_dist_q;

	tok_t                 tok   [PALETTE_DEPTH+1];
	logic [IdxW-1:0]      best_i[PALETTE_DEPTH+1];
	logic [PALETTE_DEPTH-1:0] vld_vec;
	logic                 in_acc;
	logic                 wr_acc;
	logic                 q_acc;
	logic                 last_vld;
	logic                 adv;
	logic                 load;
	logic [IdxW+IDX_OUT_W-1:0] idx_ext;

	assign cfg.ready = 1'b1;
	assign in.ready  = !busy_q;
	assign in_acc    = in.valid && in.ready;
	assign wr_acc    = in_acc && (in.opcode == OP_WRITE);
	assign q_acc     = in_acc && (in.opcode == OP_QUERY);

	assign last_vld = tok[PALETTE_DEPTH].valid;
	assign adv      = !(last_vld && out_vld_q && !out.ready);
	assign load     = last_vld && adv;

	assign tok[0].valid  = q_acc;
	assign tok[0].color  = in.color;
	assign tok[0].best_d = '1;
	assign best_i[0]     = '0;

	for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
		logic act;
		logic wen;
		assign act = (k == 0) || (32'(cnt_q) > k);
		assign wen = wr_acc && (32'(in.entry_index) == k);
		assign vld_vec[k] = tok[k+1].valid;
		npc_cell #(
			.IdxW  (IdxW),
			.Index (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.wr_en    (wen),
			.wr_color (in.color),
			.active   (act),
			.tok_i    (tok[k]),
			.best_i_i (best_i[k]),
			.tok_o    (tok[k+1]),
			.best_i_o (best_i[k+1])
		);
	end

	assign idx_ext = {{IDX_OUT_W{1'b0}}, best_i[PALETTE_DEPTH]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_RESET;
		end else if (cfg.valid) begin
			cnt_q <= cfg.entries_in_use;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (q_acc) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (out.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_idx_q  <= idx_ext[IDX_OUT_W-1:0];
			out_dist_q <= tok[PALETTE_DEPTH].best_d;
		end
	end

	assign out.valid            = out_vld_q;
	assign out.nearest_index    = out_idx_q;
	assign out.nearest_distance = out_dist_q;

	`NPC_ASSERT(a_one_token, clk, arst_n, $onehot0(vld_vec))
	`NPC_ASSERT(a_idle_empty, clk, arst_n, !busy_q |-> (vld_vec == '0))
	`NPC_ASSERT(a_query_busy, clk, arst_n, q_acc |=> busy_q)
	`NPC_ASSERT(a_result_ends, clk, arst_n, load |=> (!busy_q && out_vld_q))
	`NPC_NEVER(a_no_drop, clk, arst_n, last_vld && !adv && !out_vld_q)
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for nearest_palette_color: directed table, then random
// palette writes and nearest-color queries checked against an in-bench predictor.
// Depends on npc_pkg, the npc_*_if interfaces and the nearest_palette_color RTL.
module tb_top import npc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_OFF        = NPC_DEPTH + 8;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int ITEMS_PER_PHASE = 227;
	localparam int NUM_PHASES      = 8;
	localparam int NUM_DIRECTED    = 25;
	localparam int PAL_IDX_W       = $clog2(NPC_DEPTH);

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] idx;
		logic [DIST_W-1:0]    distance;
	} result_t;

	typedef struct packed {
		row_kind_t            kind;
		logic                 op;
		logic [5:0]           idx;
		logic [COLOR_W-1:0]   color;
		logic [CNT_W-1:0]     cfg_val;
		logic                 typed;
		logic [IDX_OUT_W-1:0] exp_idx;
		logic [DIST_W-1:0]    exp_dist;
	} step_t;

	localparam step_t DIRECTED [NUM_DIRECTED] = '{
		'{ROW_CFG, OP_WRITE, 6'd0,  24'h000000, 7'd0, 1'b0, 6'd0, 18'd0},
		'{ROW_REQ, OP_WRITE, 6'd0,  24'h000000, 7'd0, 1'b0, 6'd0, 18'd0},
		'{ROW_REQ, OP_QUERY, 6'd63, 24'hFFFFFF, 7'd0, 1'b1, 6'd0, 18'd195075},
		'{ROW_REQ, OP_WRITE, 6'd1,  24'hFFFFFF, 7'd0, 1'b0, 6'd0, 18'd0},
		'{ROW_REQ, OP_QUERY, 6'd0,  24'hFFFFFF, 7'd0, 1'b1, 6'd0, 18'd195075},
		'{ROW_CFG, OP_WRITE, 6'd0,  24'h000000, 7'd2, 1'b0, 6'd0, 18'd0},
		'{ROW_REQ, OP_QUERY, 6'd0,  24'hFFFFFF, 7'd0, 1'b1, 6'd1, 18'd0},
		'{ROW_REQ, OP_QUERY, 6'd21, 24'h000000, 7'd0, 1'b1, 6'd0, 18'd0},
		'{ROW_REQ, OP_WRITE, 6'd2,  24'hFFFFFF, 7'd0, 1'b0, 6'd0, 18'd0},
		'{ROW_REQ, OP_WRITE, 6'd3,  24'h000000, 7'd0, 1'b0, 6'd0, 18'd0},
		'{ROW_CFG, OP_WRITE, 6'd0,  24'h000000, 7'd4, 1'b0, 6'd0, 18'd0},
		'{ROW_REQ, OP_QUERY, 6'd42, 24'hFFFFFF, 7'd0, 1'b1, 6'd1, 18'd0},
		'{ROW_REQ, OP_QUERY, 6'd0,  24'h000000, 7'd0, 1'b1, 6'd0, 18'd0},
		'{ROW_REQ, OP_QUERY, 6'd0,  24'h808080, 7'd0, 1'b0, 6'd0, 18'd0},
		'{ROW_REQ, OP_WRITE, 6'd0,  24'h0000FF, 7'd0, 1'b0, 6'd0, 18'd0},
		'{ROW_REQ, OP_WRITE, 6'd1,  24'h00FF00, 7'd0, 1'b0, 6'd0, 18'd0},
		'{ROW_REQ, OP_WRITE, 6'd2,  24'hFF0000, 7'd0, 1'b0, 6'd0, 18'd0},
		'{ROW_REQ, OP_WRITE, 6'd3,  24'h123456, 7'd0, 1'b0, 6'd0, 18'd0},
		'{ROW_REQ, OP_QUERY, 6'd0,  24'h0000FF, 7'd0, 1'b1, 6'd0, 18'd0},
		'{ROW_REQ, OP_QUERY, 6'd0,  24'h00FF00, 7'd0, 1'b1, 6'd1, 18'd0},
		'{ROW_REQ, OP_QUERY, 6'd0,  24'hFF0000, 7'd0, 1'b1, 6'd2, 18'd0},
		'{ROW_REQ, OP_QUERY, 6'd0,  24'h123456, 7'd0, 1'b1, 6'd3, 18'd0},
		'{ROW_REQ, OP_QUERY, 6'd0,  24'h80FF01, 7'd0, 1'b0, 6'd0, 18'd0},
		'{ROW_REQ, OP_WRITE, 6'd63, 24'hFFFFFF, 7'd0, 1'b0, 6'd0, 18'd0},
		'{ROW_REQ, OP_QUERY, 6'd0,  24'h7F7F80, 7'd0, 1'b0, 6'd0, 18'd0}
	};

	localparam logic [CNT_W-1:0] PHASE_CFG [NUM_PHASES] = '{
		7'd64, 7'd1, 7'd127, 7'd60, 7'd33, 7'd0, 7'd65, 7'd2
	};

	logic clk = 1'b0;
	logic arst_n;

	npc_in_if  in_if ();
	npc_out_if out_if ();
	npc_cfg_if cfg_if ();

	nearest_palette_color u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_if),
		.out    (out_if),
		.cfg    (cfg_if)
	);

	always #1 clk = ~clk;

	logic [COLOR_W-1:0] palette_model [NPC_DEPTH];
	logic [CNT_W-1:0]   entries_model = CNT_RESET;
	result_t            nearest_q [$];
	int                 send_idle_pct;
	int                 recv_stall_pct;
	int                 mismatches;
	int                 requests_sent;
	int                 results_checked;
	int                 cfg_writes;

	function automatic int searched_entries();
		int count;
		count = int'(entries_model);
		if (count < 1)
			count = 1;
		if (count > NPC_DEPTH)
			count = NPC_DEPTH;
		return count;
	endfunction

	function automatic int sq_distance(input logic [COLOR_W-1:0] a, input logic [COLOR_W-1:0] b);
		int total;
		int diff;
		total = 0;
		for (int ch = 0; ch < 3; ch++) begin
			diff = int'(a[ch*CHAN_W +: CHAN_W]) - int'(b[ch*CHAN_W +: CHAN_W]);
			total += diff * diff;
		end
		return total;
	endfunction

	// strict less-than keeps the lowest index on ties
	function automatic result_t find_nearest(input logic [COLOR_W-1:0] c);
		result_t best;
		int count;
		int d;
		count = searched_entries();
		best.idx = '0;
		best.distance = DIST_W'(sq_distance(c, palette_model[0]));
		for (int i = 1; i < count; i++) begin
			d = sq_distance(c, palette_model[PAL_IDX_W'(i)]);
			if (d < int'(best.distance)) begin
				best.distance = DIST_W'(d);
				best.idx = IDX_OUT_W'(i);
			end
		end
		return best;
	endfunction

	// colors near or equal to live entries, so ties and small distances show up, plus random and extreme-channel ones
	function automatic logic [COLOR_W-1:0] pick_color();
		logic [COLOR_W-1:0] base;
		logic [COLOR_W-1:0] c;
		int sel;
		int v;
		int k;
		sel = $urandom_range(9);
		base = palette_model[PAL_IDX_W'($urandom_range(searched_entries() - 1))];
		c = COLOR_W'($urandom);
		if (sel >= 2 && sel < 5) begin
			c = base;
		end else if (sel >= 5 && sel < 8) begin
			for (int ch = 0; ch < 3; ch++) begin
				v = int'(base[ch*CHAN_W +: CHAN_W]) + int'($urandom_range(6)) - 3;
				if (v < 0)
					v = 0;
				if (v > 255)
					v = 255;
				c[ch*CHAN_W +: CHAN_W] = CHAN_W'(v);
			end
		end else if (sel == 8) begin
			for (int ch = 0; ch < 3; ch++)
				c[ch*CHAN_W +: CHAN_W] = $urandom_range(1) ? CHAN_MASK : 8'h00;
		end else if (sel == 9) begin
			k = $urandom_range(2);
			c[k*CHAN_W +: CHAN_W] = $urandom_range(1) ? CHAN_MASK : 8'h00;
		end
		return c;
	endfunction

	function automatic void set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_idle_pct = 62;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				recv_stall_pct = 62;
			end
			default: begin
				send_idle_pct = 28;
				recv_stall_pct = 28;
			end
		endcase
	endfunction

	// entered and left right after a falling edge
	task automatic send_request(input logic op, input logic [5:0] idx,
			input logic [COLOR_W-1:0] color, input logic typed, input result_t typed_res);
		if ($urandom_range(99) < send_idle_pct) begin
			in_if.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_if.valid <= 1'b1;
		in_if.opcode <= op;
		in_if.entry_index <= idx;
		in_if.color <= color;
		do @(posedge clk); while (in_if.ready !== 1'b1);
		requests_sent++;
		if (op == OP_WRITE)
			palette_model[idx] = color;
		else if (typed)
			nearest_q.push_back(typed_res);
		else
			nearest_q.push_back(find_nearest(color));
		@(negedge clk);
	endtask

	task automatic write_entries_in_use(input logic [CNT_W-1:0] value);
		in_if.valid <= 1'b0;
		while (nearest_q.size() != 0)
			@(negedge clk);
		// let the block sit idle before the search length changes
		repeat (HOLD_OFF) @(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.entries_in_use <= value;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		entries_model = value;
		cfg_writes++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	always @(negedge clk)
		out_if.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		result_t want;
		if (arst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
			if (nearest_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got index %0d distance %0d",
					$time, out_if.nearest_index, out_if.nearest_distance);
				mismatches++;
			end else begin
				want = nearest_q.pop_front();
				results_checked++;
				if (out_if.nearest_index !== want.idx) begin
					$display("%0t: nearest_index expected %0d, got %0d",
						$time, want.idx, out_if.nearest_index);
					mismatches++;
				end
				if (out_if.nearest_distance !== want.distance) begin
					$display("%0t: nearest_distance expected %0d, got %0d",
						$time, want.distance, out_if.nearest_distance);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		do begin
			@(posedge clk);
			if ((in_if.valid === 1'b1 && in_if.ready === 1'b1)
					|| (out_if.valid === 1'b1 && out_if.ready === 1'b1)
					|| (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end while (quiet < WATCHDOG_LIMIT);
		$display("%0t: no request moved for %0d cycles, %0d results outstanding",
			$time, WATCHDOG_LIMIT, nearest_q.size());
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		result_t typed_res;
		logic    op;
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.opcode = OP_WRITE;
		in_if.entry_index = '0;
		in_if.color = '0;
		out_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.entries_in_use = '0;
		mismatches = 0;
		requests_sent = 0;
		results_checked = 0;
		cfg_writes = 0;
		set_idle(IDLE_NONE);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				write_entries_in_use(DIRECTED[i].cfg_val);
			end else begin
				typed_res.idx = DIRECTED[i].exp_idx;
				typed_res.distance = DIRECTED[i].exp_dist;
				send_request(DIRECTED[i].op, DIRECTED[i].idx, DIRECTED[i].color,
					DIRECTED[i].typed, typed_res);
			end
		end

		// fill the whole palette so any entries_in_use may be searched
		set_idle(IDLE_SEND);
		typed_res = '0;
		for (int i = 0; i < NPC_DEPTH; i++)
			send_request(OP_WRITE, 6'(i), pick_color(), 1'b0, typed_res);

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_entries_in_use(PHASE_CFG[p]);
			set_idle(idle_mode_t'(p % 4));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				op = ($urandom_range(3) == 0) ? OP_WRITE : OP_QUERY;
				send_request(op, 6'($urandom_range(63)), pick_color(), 1'b0, typed_res);
			end
		end
		in_if.valid <= 1'b0;

		while (nearest_q.size() != 0)
			@(posedge clk);
		repeat (HOLD_OFF) @(posedge clk);

		$display("Sent %0d palette writes and queries, checked %0d nearest-entry results,",
			requests_sent, results_checked);
		$display("over %0d entries_in_use settings from 0 to 127 and four idle/stall mixes.",
			cfg_writes);
		if (mismatches == 0 && nearest_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
